// ===== rtl/core/zonal_stats_accumulator_unit_macros.svh =====
// Assertion macros for the zonal statistics accumulator.
// Each use expects clk and rst_n in scope.
`ifndef ZONAL_STATS_ACCUMULATOR_UNIT_MACROS_SVH
`define ZONAL_STATS_ACCUMULATOR_UNIT_MACROS_SVH

// same-cycle implication
`define ZSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ZSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/zsa_pkg.sv =====
// Shared types and codes for the zonal statistics accumulator.
// No dependencies; imported by the update unit, the top level and the checker.
package zsa_pkg;

  localparam logic OP_ACCUM   = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  localparam logic CFG_ZONES_ENABLED = 1'b0;
  localparam logic CFG_ZONE_OFFSET   = 1'b1;

  localparam logic [62:0] USUM_MAX = {63{1'b1}};
  localparam logic [63:0] SSUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] SSUM_MIN = {1'b1, {63{1'b0}}};

  // per-zone sums and extremes; seen is clear until a non-null value arrives
  typedef struct packed {
    logic [63:0] value_sum;
    logic [62:0] square_sum;
    logic [62:0] abs_sum;
    logic [31:0] minimum;
    logic [31:0] maximum;
    logic        seen;
  } stats_t;

endpackage

// ===== rtl/core/zsa_update.sv =====
// Read-modify-write datapath for one zone entry: counts, saturating sums, min/max.
// Depends on zsa_pkg (stats_t, saturation limits).
module zsa_update import zsa_pkg::*; #(
  parameter int COUNT_WIDTH = 24
) (
  input  logic [COUNT_WIDTH-1:0] cell_i,
  input  logic [COUNT_WIDTH-1:0] valid_i,
  input  stats_t                 stats_i,
  input  logic                   value_null,
  input  logic [31:0]            value,
  input  logic [31:0]            mag,
  input  logic [63:0]            product,
  output logic [COUNT_WIDTH-1:0] cell_o,
  output logic [COUNT_WIDTH-1:0] valid_o,
  output stats_t                 stats_o
);

  logic [COUNT_WIDTH-1:0] cell_inc;
  logic [COUNT_WIDTH-1:0] valid_inc;
  logic [64:0]            vsum;
  logic [63:0]            sq_sum;
  logic [63:0]            ab_sum;

  assign cell_inc  = (cell_i == '1) ? cell_i : cell_i + 1'b1;
  assign valid_inc = (valid_i == '1) ? valid_i : valid_i + 1'b1;

  // square rounded back to Q16.16: (p >> 16) plus the half bit
  assign vsum   = {stats_i.value_sum[63], stats_i.value_sum} + {{33{value[31]}}, value};
  assign sq_sum = {1'b0, stats_i.square_sum} + {16'd0, product[63:16]} + 64'(product[15]);
  assign ab_sum = {1'b0, stats_i.abs_sum} + {32'd0, mag};

  always_comb begin
    cell_o  = cell_inc;
    valid_o = valid_i;
    stats_o = stats_i;
    if (!value_null) begin
      valid_o = valid_inc;
      if (vsum[64] != vsum[63]) begin
        stats_o.value_sum = vsum[64] ? SSUM_MIN : SSUM_MAX;
      end else begin
        stats_o.value_sum = vsum[63:0];
      end
      stats_o.square_sum = sq_sum[63] ? USUM_MAX : sq_sum[62:0];
      stats_o.abs_sum    = ab_sum[63] ? USUM_MAX : ab_sum[62:0];
      if (!stats_i.seen) begin
        stats_o.minimum = value;
        stats_o.maximum = value;
      end else begin
        if ($signed(value) > $signed(stats_i.maximum)) stats_o.maximum = value;
        if ($signed(value) < $signed(stats_i.minimum)) stats_o.minimum = value;
      end
      stats_o.seen = 1'b1;
    end
  end

endmodule

// ===== rtl/core/zonal_stats_accumulator_unit.sv =====
// Zonal statistics accumulator: top level with the zone memory and sequencer.
// Depends on zsa_pkg and zsa_update.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per accept. Operation
//   accumulate adds one voxel to its zone and returns nothing; operation
//   readout returns one result with that zone's counts, sums and extremes.
//   Output channel (out_valid / out_stall): one result per readout, in order.
//   Config port: cfg_we writes register cfg_index with cfg_data;
//   write only while no request is in flight.
// Sequencing:
//   Every request costs one memory read and one write-back slot of the zone
//   entry, so a new request is taken only once the last one is in write-back.
//   A readout's result is loaded into the output register in write-back.
//   While a result waits under out_stall the next request is still accepted;
//   a readout that reaches write-back then holds there until the output
//   register frees, and input stalls meanwhile.
// Reset:
//   rst_n low clears the config, sequencer and output-valid registers. After
//   release a clearing pass zeroes the ZONE_COUNT memory entries, one per cycle;
//   in_stall stays high during the pass, config writes are taken as usual.
module zonal_stats_accumulator_unit import zsa_pkg::*; #(
  parameter int ZONE_COUNT  = 256,
  parameter int COUNT_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  // input requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_sample_value,
  input  logic        in_value_null,
  input  logic [31:0] in_zone_label,
  input  logic        in_zone_null,
  input  logic [7:0]  in_read_zone,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_zone_index,
  output logic [23:0] out_cell_count,
  output logic [23:0] out_valid_count,
  output logic [63:0] out_value_sum,
  output logic [62:0] out_square_sum,
  output logic [62:0] out_abs_sum,
  output logic [31:0] out_minimum,
  output logic [31:0] out_maximum,
  output logic        out_zone_empty
);

  localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
  localparam int XW = (COUNT_WIDTH > 24) ? COUNT_WIDTH : 24;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] cells;
    logic [COUNT_WIDTH-1:0] valid;
    stats_t                 stats;
  } entry_t;

  // config registers
  logic        zen_r;
  logic [23:0] zoff_r;

  // sequencer
  logic [1:0]    state_r, state_nxt;
  logic [ZW-1:0] clr_addr_r;
  logic          accept;
  logic          wb_done;

  // captured request
  logic        op_r;
  logic [31:0] value_r;
  logic [31:0] mag_r;
  logic        vnull_r;
  logic [24:0] rnd_r;
  logic        znull_r;
  logic [7:0]  rzone_r;

  // label rounding at capture
  logic        lab_neg;
  logic [32:0] lab_abs;
  logic [32:0] lab_half;
  logic [24:0] rnd_mag;
  logic [24:0] rnd_val;
  logic [31:0] val_abs;

  // address formation in the read cycle
  logic [26:0]   zone_diff;
  logic          acc_hit;
  logic [ZW-1:0] acc_addr;
  logic [7:0]    rz;
  logic [16:0]   rz_w;
  logic          rd_hit;
  logic [ZW-1:0] rd_addr;

  // write-back side
  logic          hit_r;
  logic [ZW-1:0] addr_r;
  logic [7:0]    rz_r;
  logic [63:0]   product_r;

  // zone memory
  entry_t        zone_mem [ZONE_COUNT];
  entry_t        rdata_r;
  logic          mem_we;
  logic [ZW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [ZW-1:0] mem_raddr;
  entry_t        upd_entry;

  // output register
  logic          out_valid_r;
  logic          out_load;
  logic [XW-1:0] cell_x;
  logic [XW-1:0] valid_x;
  logic [7:0]    out_zone_index_r;
  logic [23:0]   out_cell_count_r;
  logic [23:0]   out_valid_count_r;
  logic [63:0]   out_value_sum_r;
  logic [62:0]   out_square_sum_r;
  logic [62:0]   out_abs_sum_r;
  logic [31:0]   out_minimum_r;
  logic [31:0]   out_maximum_r;
  logic          out_zone_empty_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zen_r  <= 1'b0;
      zoff_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZONES_ENABLED: zen_r  <= cfg_data[0];
        CFG_ZONE_OFFSET:   zoff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- handshake
  // a readout in write-back needs a free output slot; accumulates always finish
  assign wb_done  = (op_r == OP_ACCUM) || !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) || ((state_r == ST_WRITE) && wb_done));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == ZW'(ZONE_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (wb_done) state_nxt = accept ? ST_READ : ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // ---------------------------------------------------------------- capture
  // half away from zero: round the magnitude, then restore the sign
  assign lab_neg  = in_zone_label[31];
  assign lab_abs  = lab_neg ? (33'd0 - {in_zone_label[31], in_zone_label})
                            : {1'b0, in_zone_label};
  assign lab_half = lab_abs + 33'd128;
  assign rnd_mag  = lab_half[32:8];
  assign rnd_val  = lab_neg ? (25'd0 - rnd_mag) : rnd_mag;
  assign val_abs  = in_sample_value[31] ? (32'd0 - in_sample_value) : in_sample_value;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_operation;
      value_r <= in_sample_value;
      mag_r   <= val_abs;
      vnull_r <= in_value_null;
      rnd_r   <= rnd_val;
      znull_r <= in_zone_null;
      rzone_r <= in_read_zone;
    end
  end

  // ---------------------------------------------------------------- read cycle
  assign zone_diff = {{2{rnd_r[24]}}, rnd_r} - {{3{zoff_r[23]}}, zoff_r};
  // zones disabled: everything lands in zone 0, zone_null ignored
  assign acc_hit   = !zen_r ||
                     (!znull_r && !zone_diff[26] && (zone_diff[25:0] < 26'(ZONE_COUNT)));
  assign acc_addr  = zen_r ? zone_diff[ZW-1:0] : '0;

  assign rz      = zen_r ? rzone_r : 8'd0;
  assign rz_w    = 17'(rz);
  assign rd_hit  = rz_w < 17'(ZONE_COUNT);
  assign rd_addr = rz_w[ZW-1:0];

  assign mem_re    = (state_r == ST_READ);
  assign mem_raddr = (op_r == OP_READOUT) ? rd_addr : acc_addr;

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      hit_r     <= (op_r == OP_READOUT) ? rd_hit : acc_hit;
      addr_r    <= mem_raddr;
      rz_r      <= rz;
      product_r <= mag_r * mag_r;
    end
  end

  // ---------------------------------------------------------------- memory
  // one write, one registered read per cycle; the write-back of a request
  // lands before the next request's read, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) zone_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_r <= zone_mem[mem_raddr];
  end

  zsa_update #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .cell_i     (rdata_r.cells),
    .valid_i    (rdata_r.valid),
    .stats_i    (rdata_r.stats),
    .value_null (vnull_r),
    .value      (value_r),
    .mag        (mag_r),
    .product    (product_r),
    .cell_o     (upd_entry.cells),
    .valid_o    (upd_entry.valid),
    .stats_o    (upd_entry.stats)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = upd_entry;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if ((state_r == ST_WRITE) && (op_r == OP_ACCUM) && hit_r) begin
      mem_we = 1'b1;
    end
  end

  // ---------------------------------------------------------------- results
  assign out_load = (state_r == ST_WRITE) && (op_r == OP_READOUT) && wb_done;
  assign cell_x   = XW'(rdata_r.cells);
  assign valid_x  = XW'(rdata_r.valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_zone_index_r <= rz_r;
      if (hit_r) begin
        out_cell_count_r  <= (cell_x > XW'(24'hFFFFFF)) ? 24'hFFFFFF : cell_x[23:0];
        out_valid_count_r <= (valid_x > XW'(24'hFFFFFF)) ? 24'hFFFFFF : valid_x[23:0];
        out_value_sum_r   <= rdata_r.stats.value_sum;
        out_square_sum_r  <= rdata_r.stats.square_sum;
        out_abs_sum_r     <= rdata_r.stats.abs_sum;
        out_minimum_r     <= rdata_r.stats.seen ? rdata_r.stats.minimum : 32'd0;
        out_maximum_r     <= rdata_r.stats.seen ? rdata_r.stats.maximum : 32'd0;
        out_zone_empty_r  <= !rdata_r.stats.seen;
      end else begin
        // zone beyond the store: report it as empty
        out_cell_count_r  <= '0;
        out_valid_count_r <= '0;
        out_value_sum_r   <= '0;
        out_square_sum_r  <= '0;
        out_abs_sum_r     <= '0;
        out_minimum_r     <= '0;
        out_maximum_r     <= '0;
        out_zone_empty_r  <= 1'b1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_zone_index  = out_zone_index_r;
  assign out_cell_count  = out_cell_count_r;
  assign out_valid_count = out_valid_count_r;
  assign out_value_sum   = out_value_sum_r;
  assign out_square_sum  = out_square_sum_r;
  assign out_abs_sum     = out_abs_sum_r;
  assign out_minimum     = out_minimum_r;
  assign out_maximum     = out_maximum_r;
  assign out_zone_empty  = out_zone_empty_r;

endmodule

// ===== rtl/core/zsa_checker.sv =====
// Port-level checks for the zonal statistics accumulator, bound to the top level.
// Depends on zsa_pkg and zonal_stats_accumulator_unit_macros.svh.
`include "zonal_stats_accumulator_unit_macros.svh"

module zsa_checker import zsa_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_zone_index,
  input logic [23:0] out_cell_count,
  input logic [23:0] out_valid_count,
  input logic [63:0] out_value_sum,
  input logic [31:0] out_minimum,
  input logic [31:0] out_maximum,
  input logic        out_zone_empty
);

  // a fresh result follows a readout request by a read and a write-back slot
  `ZSA_ASSERT_IMPL(a_result_source, $rose(out_valid), $past(in_valid && !in_stall && in_operation == OP_READOUT, 3), "result without matching readout request")

  // empty flag agrees with a zero valid count and zeroed extremes
  `ZSA_ASSERT_IMPL(a_empty_zone, out_valid && out_zone_empty, out_valid_count == 24'd0 && out_minimum == 32'd0 && out_maximum == 32'd0, "empty zone reports data")

  `ZSA_ASSERT_IMPL(a_filled_zone, out_valid && !out_zone_empty, out_valid_count != 24'd0 && out_cell_count >= out_valid_count, "filled zone counts inconsistent")

  `ZSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_zone_index) && $stable(out_value_sum), "stalled result changed")

endmodule

bind zonal_stats_accumulator_unit zsa_checker u_zsa_checker (.*);
